// ----- rtl/mec_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mec_pkg;

    localparam int FRAC_BITS = 28;
    localparam int C_W       = 32;
    localparam int OP_W      = FRAC_BITS + 2;
    localparam int PROD_W    = 2 * OP_W;
    localparam int ITER_W    = ((FRAC_BITS + 4 > C_W) ? FRAC_BITS + 4 : C_W) + 1;
    localparam int CNT_W     = 12;
    localparam int COLOR_W   = 24;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 24;
    localparam int CH_W      = 8;
    localparam int WIDE_CH_W = 14;

    localparam int COLOR_SPLIT = 50;
    localparam int COLOR_BIAS  = 50;
    localparam int RED_LOW     = 10;

    localparam logic [CNT_W-1:0]   MAX_ITER_RST = CNT_W'(50);
    localparam logic [COLOR_W-1:0] BG_RST       = '0;

    localparam logic signed [ITER_W-1:0] BAIL_LIM = ITER_W'(1) <<< (FRAC_BITS + 1);
    localparam logic signed [ITER_W-1:0] BAIL_NEG = -BAIL_LIM;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_ITER = 1'b0,
        CFG_BG       = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SQ_IM,
        ST_CROSS,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MUL_RR,
        MUL_II,
        MUL_RI
    } mul_sel_t;

    typedef struct packed {
        logic     start;
        mul_sel_t mul_sel;
        logic     acc_load;
        logic     acc_sub;
        logic     update;
    } dp_ctrl_t;

    function automatic logic [CH_W-1:0] sat8(input logic [WIDE_CH_W-1:0] v);
        return (v > WIDE_CH_W'(255)) ? {CH_W{1'b1}} : v[CH_W-1:0];
    endfunction

    function automatic logic [COLOR_W-1:0] escape_color(input logic [CNT_W-1:0] n);
        logic [WIDE_CH_W-1:0] n_w;
        logic [WIDE_CH_W-1:0] twice;
        logic [WIDE_CH_W-1:0] thrice;
        logic [WIDE_CH_W-1:0] red_hi;
        logic [WIDE_CH_W-1:0] blue_hi;
        n_w     = WIDE_CH_W'(n);
        twice   = n_w << 1;
        thrice  = twice + n_w;
        red_hi  = n_w + WIDE_CH_W'(COLOR_BIAS);
        blue_hi = twice + WIDE_CH_W'(COLOR_BIAS);
        if (n != '0 && n < CNT_W'(COLOR_SPLIT))
            return {CH_W'(RED_LOW), sat8(twice), sat8(thrice)};
        else
            return {sat8(red_hi), sat8(twice), sat8(blue_hi)};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mec_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mec_datapath
(
    input  wire logic                                clk,
    input  wire mec_pkg::dp_ctrl_t                   ctrl,
    input  wire logic signed [mec_pkg::C_W-1:0]      c_real,
    input  wire logic signed [mec_pkg::C_W-1:0]      c_imag,
    output logic                                     in_box
);

    logic signed [mec_pkg::C_W-1:0]    cre_reg;
    logic signed [mec_pkg::C_W-1:0]    cim_reg;
    logic signed [mec_pkg::ITER_W-1:0] re_reg;
    logic signed [mec_pkg::ITER_W-1:0] re_next;
    logic signed [mec_pkg::ITER_W-1:0] im_reg;
    logic signed [mec_pkg::ITER_W-1:0] im_next;
    logic signed [mec_pkg::PROD_W-1:0] prod_reg;
    logic signed [mec_pkg::PROD_W-1:0] prod_next;
    logic signed [mec_pkg::PROD_W-1:0] acc_reg;
    logic signed [mec_pkg::OP_W-1:0]   re_op;
    logic signed [mec_pkg::OP_W-1:0]   im_op;
    logic signed [mec_pkg::OP_W-1:0]   mul_a;
    logic signed [mec_pkg::OP_W-1:0]   mul_b;

    assign re_op = $signed(re_reg[mec_pkg::OP_W-1:0]);
    assign im_op = $signed(im_reg[mec_pkg::OP_W-1:0]);

    always_comb
    begin
        case (ctrl.mul_sel)
            mec_pkg::MUL_RR:
            begin
                mul_a = re_op;
                mul_b = re_op;
            end
            mec_pkg::MUL_II:
            begin
                mul_a = im_op;
                mul_b = im_op;
            end
            mec_pkg::MUL_RI:
            begin
                mul_a = re_op;
                mul_b = im_op;
            end
            default:
            begin
                mul_a = re_op;
                mul_b = re_op;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    assign re_next = mec_pkg::ITER_W'(acc_reg >>> mec_pkg::FRAC_BITS)
                   + mec_pkg::ITER_W'(cre_reg);
    assign im_next = mec_pkg::ITER_W'(prod_reg >>> (mec_pkg::FRAC_BITS - 1))
                   + mec_pkg::ITER_W'(cim_reg);

    assign in_box = (re_reg < mec_pkg::BAIL_LIM) && (re_reg > mec_pkg::BAIL_NEG)
                 && (im_reg < mec_pkg::BAIL_LIM) && (im_reg > mec_pkg::BAIL_NEG);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (ctrl.start)
        begin
            cre_reg <= c_real;
            cim_reg <= c_imag;
            re_reg  <= '0;
            im_reg  <= '0;
        end
        else if (ctrl.update)
        begin
            re_reg <= re_next;
            im_reg <= im_next;
        end
        if (ctrl.acc_load)
            acc_reg <= prod_reg;
        else if (ctrl.acc_sub)
            acc_reg <= acc_reg - prod_reg;
    end

endmodule

`default_nettype wire

// ----- rtl/mec_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mec_ctrl
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic                        out_ready,
    input  wire logic [mec_pkg::CNT_W-1:0]   max_iterations,
    input  wire logic                        in_box,
    output logic                             in_ready,
    output logic                             out_valid,
    output logic                             finish,
    output mec_pkg::dp_ctrl_t                ctrl,
    output logic [mec_pkg::CNT_W-1:0]        iter_count
);

    mec_pkg::state_t             state_reg;
    mec_pkg::state_t             state_next;
    logic [mec_pkg::CNT_W-1:0]   iter_reg;
    logic [mec_pkg::CNT_W-1:0]   iter_next;
    logic                        go_on;

    assign go_on = (iter_reg < max_iterations) && in_box;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mec_pkg::ST_IDLE:
                if (in_valid)
                    state_next = mec_pkg::ST_CHECK;
            mec_pkg::ST_CHECK:
                state_next = go_on ? mec_pkg::ST_SQ_IM : mec_pkg::ST_DONE;
            mec_pkg::ST_SQ_IM:
                state_next = mec_pkg::ST_CROSS;
            mec_pkg::ST_CROSS:
                state_next = mec_pkg::ST_UPDATE;
            mec_pkg::ST_UPDATE:
                state_next = mec_pkg::ST_CHECK;
            mec_pkg::ST_DONE:
                if (out_ready)
                    state_next = mec_pkg::ST_IDLE;
            default:
                state_next = mec_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = (state_reg == mec_pkg::ST_IDLE);
        out_valid     = (state_reg == mec_pkg::ST_DONE);
        finish        = (state_reg == mec_pkg::ST_CHECK) && !go_on;
        ctrl.start    = (state_reg == mec_pkg::ST_IDLE) && in_valid;
        ctrl.acc_load = (state_reg == mec_pkg::ST_SQ_IM);
        ctrl.acc_sub  = (state_reg == mec_pkg::ST_CROSS);
        ctrl.update   = (state_reg == mec_pkg::ST_UPDATE);
        case (state_reg)
            mec_pkg::ST_SQ_IM: ctrl.mul_sel = mec_pkg::MUL_II;
            mec_pkg::ST_CROSS: ctrl.mul_sel = mec_pkg::MUL_RI;
            default:           ctrl.mul_sel = mec_pkg::MUL_RR;
        endcase
        iter_next = iter_reg;
        if (ctrl.start)
            iter_next = '0;
        else if (ctrl.update)
            iter_next = iter_reg + mec_pkg::CNT_W'(1);
    end

    assign iter_count = iter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mec_pkg::ST_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == mec_pkg::ST_CHECK && iter_reg == '0))
        else $error("start did not clear the count");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mec_pkg::ST_UPDATE) |=>
            (iter_reg == $past(iter_reg) + mec_pkg::CNT_W'(1)))
        else $error("count did not advance on update");

    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (out_valid && !in_ready))
        else $error("finished item not presented");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(iter_reg)))
        else $error("stalled result lost");

endmodule

`default_nettype wire

// ----- rtl/mandelbrot_escape_color.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Each iteration runs on the single shared multiplier as the steps re*re, im*im, re*im, update.
// The next input transfer follows the output transfer, since the multiplier and
// sequencer serve one point at a time.
// Reset: control state clears, max_iterations returns to 50 and background_color to 0.

module mandelbrot_escape_color
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [mec_pkg::C_W-1:0]      c_real,
    input  wire logic signed [mec_pkg::C_W-1:0]      c_imag,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [mec_pkg::COLOR_W-1:0]              pixel_color,
    output logic [mec_pkg::CNT_W-1:0]                iterations_used,
    output logic                                     escaped,
    input  wire logic                                cfg_we,
    input  wire logic [mec_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [mec_pkg::CFG_W-1:0]           cfg_data
);

    logic [mec_pkg::CNT_W-1:0]   max_iter_reg;
    logic [mec_pkg::COLOR_W-1:0] bg_reg;
    logic [mec_pkg::COLOR_W-1:0] color_reg;
    logic [mec_pkg::COLOR_W-1:0] color_next;
    logic [mec_pkg::CNT_W-1:0]   used_reg;
    logic                        escaped_reg;
    logic                        in_box;
    logic                        finish;
    logic [mec_pkg::CNT_W-1:0]   iter_count;
    mec_pkg::dp_ctrl_t           dp_ctrl;

    mec_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .out_ready      (out_ready),
        .max_iterations (max_iter_reg),
        .in_box         (in_box),
        .in_ready       (in_ready),
        .out_valid      (out_valid),
        .finish         (finish),
        .ctrl           (dp_ctrl),
        .iter_count     (iter_count)
    );

    mec_datapath u_datapath
    (
        .clk    (clk),
        .ctrl   (dp_ctrl),
        .c_real (c_real),
        .c_imag (c_imag),
        .in_box (in_box)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= mec_pkg::MAX_ITER_RST;
            bg_reg       <= mec_pkg::BG_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mec_pkg::CFG_MAX_ITER: max_iter_reg <= cfg_data[mec_pkg::CNT_W-1:0];
                mec_pkg::CFG_BG:       bg_reg       <= cfg_data[mec_pkg::COLOR_W-1:0];
                default:               bg_reg       <= bg_reg;
            endcase
        end
    end

    assign color_next = in_box ? bg_reg : mec_pkg::escape_color(iter_count);

    // hold the result until its transfer
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            color_reg   <= color_next;
            used_reg    <= iter_count;
            escaped_reg <= !in_box;
        end
    end

    assign pixel_color     = color_reg;
    assign iterations_used = used_reg;
    assign escaped         = escaped_reg;

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int DIRECTED_N     = 22;
    localparam int RANDOM_ITEMS   = 1110;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AT        = 60;

    typedef struct packed {
        logic [mec_pkg::COLOR_W-1:0] color;
        logic [mec_pkg::CNT_W-1:0]   iters;
        logic                        esc;
    } pixel_t;

    typedef struct packed {
        logic [mec_pkg::C_W-1:0] re;
        logic [mec_pkg::C_W-1:0] im;
        logic                    typed;
        pixel_t                  want;
    } point_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic signed [mec_pkg::C_W-1:0] c_real = '0;
    logic signed [mec_pkg::C_W-1:0] c_imag = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [mec_pkg::COLOR_W-1:0]    pixel_color;
    logic [mec_pkg::CNT_W-1:0]      iterations_used;
    logic                           escaped;
    logic                           cfg_we = 1'b0;
    logic [mec_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mec_pkg::CFG_W-1:0]      cfg_data = '0;

    logic [mec_pkg::CNT_W-1:0]      iter_limit = mec_pkg::CNT_W'(50);
    logic [mec_pkg::COLOR_W-1:0]    bg_color = '0;
    pixel_t                         pending_pixels [$];
    point_row_t                     directed_rows [DIRECTED_N];
    int                             fail_count = 0;
    int                             quiet_cycles = 0;
    bit                             calm = 1'b0;

    always #2 clk = ~clk;

    mandelbrot_escape_color u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .c_real          (c_real),
        .c_imag          (c_imag),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pixel_color     (pixel_color),
        .iterations_used (iterations_used),
        .escaped         (escaped),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    function automatic int clamp_channel(input int v);
        return (v > 255) ? 255 : v;
    endfunction

    function automatic pixel_t escape_pixel(input logic signed [mec_pkg::C_W-1:0] cr,
                                            input logic signed [mec_pkg::C_W-1:0] ci);
        longint re;
        longint im;
        longint re_next;
        longint bound;
        int     n;
        int     red;
        int     grn;
        int     blu;
        pixel_t px;
        bound = longint'(1) <<< (mec_pkg::FRAC_BITS + 1);
        re = 0;
        im = 0;
        n = 0;
        while (n < int'(iter_limit) && re < bound && re > -bound && im < bound && im > -bound)
        begin
            re_next = ((re * re - im * im) >>> mec_pkg::FRAC_BITS) + longint'(cr);
            im = ((re * im) >>> (mec_pkg::FRAC_BITS - 1)) + longint'(ci);
            re = re_next;
            n++;
        end
        px.iters = mec_pkg::CNT_W'(n);
        if (re < bound && re > -bound && im < bound && im > -bound)
        begin
            px.color = bg_color;
            px.esc = 1'b0;
        end
        else
        begin
            if (n >= 1 && n < 50)
            begin
                red = 10;
                grn = clamp_channel(2 * n);
                blu = clamp_channel(3 * n);
            end
            else
            begin
                red = clamp_channel(50 + n);
                grn = clamp_channel(2 * n);
                blu = clamp_channel(50 + 2 * n);
            end
            px.color = {8'(red), 8'(grn), 8'(blu)};
            px.esc = 1'b1;
        end
        return px;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    task automatic random_point(output logic signed [mec_pkg::C_W-1:0] cr,
                                output logic signed [mec_pkg::C_W-1:0] ci);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            cr = mec_pkg::C_W'($urandom_range(0, 32'h3000_0000)) - 32'h2400_0000;
            ci = mec_pkg::C_W'($urandom_range(0, 32'h2800_0000)) - 32'h1400_0000;
        end
        else if (r < 80)
        begin
            cr = mec_pkg::C_W'($urandom_range(0, 32'h1400_0000)) - 32'h0A00_0000;
            ci = mec_pkg::C_W'($urandom_range(0, 32'h1400_0000)) - 32'h0A00_0000;
        end
        else if (r < 90)
        begin
            cr = mec_pkg::C_W'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000;
            ci = mec_pkg::C_W'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000;
        end
        else
        begin
            cr = $urandom;
            ci = $urandom;
        end
    endtask

    // Offer one point and hold it until the transfer; record its pixel on acceptance.
    task automatic push_point(input logic signed [mec_pkg::C_W-1:0] cr,
                              input logic signed [mec_pkg::C_W-1:0] ci,
                              input pixel_t px);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        c_real <= cr;
        c_imag <= ci;
        do
            @(posedge clk);
        while (!in_ready);
        pending_pixels.push_back(px);
    endtask

    task automatic settle();
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic configure(input logic [mec_pkg::CNT_W-1:0] limit,
                             input logic [mec_pkg::COLOR_W-1:0] shade);
        cfg_we <= 1'b1;
        cfg_index <= mec_pkg::CFG_MAX_ITER;
        cfg_data <= {12'($urandom), limit};
        @(posedge clk);
        cfg_index <= mec_pkg::CFG_BG;
        cfg_data <= shade;
        @(posedge clk);
        cfg_we <= 1'b0;
        iter_limit = limit;
        bg_color = shade;
    endtask

    task automatic compare_field(input string what, input int want, input int got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, what, want, got);
        end
    endtask

    initial
    begin : result_sink
        pixel_t want;
        int     stall;
        int     transfers;
        stall = 0;
        transfers = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                transfers++;
                if (pending_pixels.size() == 0)
                begin
                    fail_count++;
                    $display("%0t ns: pixel with no point pending, actual 0x%0h/%0d/%0b",
                             $time, pixel_color, iterations_used, escaped);
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    compare_field("pixel_color", want.color, pixel_color);
                    compare_field("iterations_used", want.iters, iterations_used);
                    compare_field("escaped", want.esc, escaped);
                end
                stall = (transfers == HOLD_AT) ? LONG_HOLD : (calm ? 0 : pick_gap());
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        pixel_t                         px;
        logic signed [mec_pkg::C_W-1:0] cr;
        logic signed [mec_pkg::C_W-1:0] ci;
        logic [mec_pkg::CNT_W-1:0]      limit;
        logic [mec_pkg::COLOR_W-1:0]    shade;
        int                             sent;
        int                             batch;
        int                             r;
        int                             phase;
        directed_rows = '{
            '{32'h0000_0000, 32'h0000_0000, 1'b1, '{24'h000000, 12'd50, 1'b0}},
            '{32'h2000_0000, 32'h0000_0000, 1'b1, '{24'h0A0203, 12'd1, 1'b1}},
            '{32'hE000_0000, 32'h0000_0000, 1'b1, '{24'h0A0203, 12'd1, 1'b1}},
            '{32'h0000_0000, 32'h2000_0000, 1'b1, '{24'h0A0203, 12'd1, 1'b1}},
            '{32'h0000_0000, 32'hE000_0000, 1'b1, '{24'h0A0203, 12'd1, 1'b1}},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, '{24'h0A0203, 12'd1, 1'b1}},
            '{32'h8000_0000, 32'h8000_0000, 1'b1, '{24'h0A0203, 12'd1, 1'b1}},
            '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{24'h0A0203, 12'd1, 1'b1}},
            '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{24'h0A0203, 12'd1, 1'b1}},
            '{32'h1FFF_FFFF, 32'h0000_0000, 1'b1, '{24'h0A0406, 12'd2, 1'b1}},
            '{32'hF000_0000, 32'h0000_0000, 1'b1, '{24'h000000, 12'd50, 1'b0}},
            '{32'h0000_0000, 32'h1000_0000, 1'b1, '{24'h000000, 12'd50, 1'b0}},
            '{32'h1FFF_FFFF, 32'h1FFF_FFFF, 1'b0, '0},
            '{32'hE000_0001, 32'h0000_0000, 1'b0, '0},
            '{32'h0400_0000, 32'h0000_0000, 1'b0, '0},
            '{32'h0404_0000, 32'h0000_0000, 1'b0, '0},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
            '{32'h0000_0001, 32'h0000_0001, 1'b0, '0},
            '{32'h1FFF_FFFF, 32'hE000_0001, 1'b0, '0},
            '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
            '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
            '{32'hC000_0000, 32'h0000_0000, 1'b0, '0}
        };
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            px = directed_rows[i].typed ? directed_rows[i].want
                                        : escape_pixel(directed_rows[i].re, directed_rows[i].im);
            push_point(directed_rows[i].re, directed_rows[i].im, px);
        end
        in_valid <= 1'b0;
        settle();

        configure('0, 24'hFFFFFF);
        repeat (10)
        begin
            random_point(cr, ci);
            push_point(cr, ci, escape_pixel(cr, ci));
        end
        in_valid <= 1'b0;
        settle();

        // slow escapes near the cusp saturate the channels
        configure(12'hFFF, 24'($urandom));
        push_point('0, '0, escape_pixel('0, '0));
        push_point(32'h0400_0400, '0, escape_pixel(32'h0400_0400, '0));
        push_point(32'h0404_0000, '0, escape_pixel(32'h0404_0000, '0));
        push_point(32'hE000_0001, '0, escape_pixel(32'hE000_0001, '0));
        push_point(32'h0401_0000, 32'h0000_4000, escape_pixel(32'h0401_0000, 32'h0000_4000));
        in_valid <= 1'b0;
        settle();

        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            batch = $urandom_range(30, 70);
            if (r < 8)
                limit = '0;
            else if (r < 20)
                limit = mec_pkg::CNT_W'($urandom_range(1, 4));
            else if (r < 75)
                limit = mec_pkg::CNT_W'($urandom_range(5, 64));
            else if (r < 95)
                limit = mec_pkg::CNT_W'($urandom_range(65, 200));
            else
            begin
                limit = mec_pkg::CNT_W'($urandom_range(201, 600));
                batch = 10;
            end
            r = $urandom_range(0, 99);
            shade = (r < 15) ? 24'h000000 : (r < 30) ? 24'hFFFFFF : 24'($urandom);
            calm = (phase % 4 == 3);
            configure(limit, shade);
            repeat (batch)
            begin
                random_point(cr, ci);
                push_point(cr, ci, escape_pixel(cr, ci));
            end
            in_valid <= 1'b0;
            settle();
            sent += batch;
            phase++;
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/mec_pkg.sv
rtl/mec_datapath.sv
rtl/mec_ctrl.sv
rtl/mandelbrot_escape_color.sv
sim/testbench.sv
